// File: rtl/lsgs_pkg.sv
// lsgs_pkg: shared types, constants and helpers for the laser scan gap selector
// no dependencies; imported by every module of the block
package lsgs_pkg;

    localparam int unsigned MAX_BEAMS = 181;

    localparam logic [15:0] DIST_THR_RESET = 16'd1000;
    localparam logic [7:0]  MIN_RUN_RESET  = 8'd20;
    localparam logic [7:0]  TARGET_RESET   = 8'd90;

    // configuration register indexes
    localparam logic [1:0] CFG_DIST_THR = 2'd0;
    localparam logic [1:0] CFG_MIN_RUN  = 2'd1;
    localparam logic [1:0] CFG_TARGET   = 2'd2;

    typedef struct packed {
        logic [15:0] range_mm;
        logic        last_sample;
    } lsgs_in_t;

    typedef struct packed {
        logic       gap_found;
        logic [7:0] gap_index;
    } lsgs_out_t;

    typedef struct packed {
        logic [15:0] distance_threshold;
        logic [7:0]  min_run_length;
        logic [7:0]  target_index;
    } lsgs_cfg_t;

    typedef struct packed {
        logic [7:0] beam_counter;
        logic [7:0] open_run_length;
        logic [7:0] best_midpoint;
        logic       best_valid;
    } lsgs_state_t;

    function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
        abs_diff = (a >= b) ? (a - b) : (b - a);
    endfunction

endpackage

// File: rtl/lsgs_cfg.sv
// lsgs_cfg: configuration register file of the gap selector
// depends on lsgs_pkg
module lsgs_cfg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_data,
    output lsgs_pkg::lsgs_cfg_t cfg
);
    import lsgs_pkg::*;

    lsgs_cfg_t cfg_reg;
    lsgs_cfg_t cfg_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_DIST_THR: cfg_next.distance_threshold = cfg_data;
                CFG_MIN_RUN:  cfg_next.min_run_length     = cfg_data[7:0];
                CFG_TARGET:   cfg_next.target_index       = cfg_data[7:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.distance_threshold <= DIST_THR_RESET;
            cfg_reg.min_run_length     <= MIN_RUN_RESET;
            cfg_reg.target_index       <= TARGET_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/lsgs_step.sv
// lsgs_step: per-sample run tracking and best-midpoint update
// depends on lsgs_pkg; purely combinational, registered by the top level
module lsgs_step (
    input  lsgs_pkg::lsgs_in_t    item,
    input  lsgs_pkg::lsgs_cfg_t   cfg,
    input  lsgs_pkg::lsgs_state_t state,
    output lsgs_pkg::lsgs_state_t state_next,
    output logic                  scan_end,
    output lsgs_pkg::lsgs_out_t   result
);
    import lsgs_pkg::*;

    localparam logic [7:0] LAST_IDX = 8'(MAX_BEAMS - 1);

    logic       is_free;
    logic [7:0] run_inc;
    logic [7:0] run_upd;
    logic       close_offer;
    logic [7:0] close_mid;
    logic       close_better;
    logic       valid_upd;
    logic [7:0] mid_upd;
    logic       tail_take;
    logic [8:0] tail_n;
    logic [8:0] tail_half;
    logic [7:0] tail_mid;
    logic       found;
    logic [7:0] final_mid;

    always_comb
    begin
        is_free  = item.range_mm > cfg.distance_threshold;
        run_inc  = (state.open_run_length != 8'hFF) ? state.open_run_length + 8'd1
                                                     : state.open_run_length;
        run_upd  = is_free ? run_inc : 8'd0;

        // a run closed by a blocked beam offers its midpoint
        close_offer  = !is_free && (state.open_run_length > cfg.min_run_length);
        close_mid    = state.beam_counter - {1'b0, state.open_run_length[7:1]};
        close_better = !state.best_valid ||
                       (abs_diff(close_mid, cfg.target_index) <
                        abs_diff(state.best_midpoint, cfg.target_index));
        valid_upd    = state.best_valid || close_offer;
        mid_upd      = (close_offer && close_better) ? close_mid : state.best_midpoint;

        scan_end = item.last_sample || (state.beam_counter >= LAST_IDX);

        // open run at scan end counts only when nothing was kept
        tail_take = scan_end && (run_upd > cfg.min_run_length) && !valid_upd;
        tail_n    = {1'b0, state.beam_counter} + 9'd1;
        tail_half = {2'b00, run_upd[7:1]};
        tail_mid  = (tail_n >= tail_half) ? 8'(tail_n - tail_half) : 8'd0;

        found     = valid_upd || tail_take;
        final_mid = tail_take ? tail_mid : mid_upd;

        result.gap_found = found;
        result.gap_index = found ? final_mid : 8'd0;

        if (scan_end)
        begin
            state_next.beam_counter    = 8'd0;
            state_next.open_run_length = 8'd0;
            state_next.best_midpoint   = final_mid;
            state_next.best_valid      = 1'b0;
        end
        else
        begin
            state_next.beam_counter    = state.beam_counter + 8'd1;
            state_next.open_run_length = run_upd;
            state_next.best_midpoint   = mid_upd;
            state_next.best_valid      = valid_upd;
        end
    end

endmodule

// File: rtl/laser_scan_gap_selector_core.sv
// laser_scan_gap_selector_core: top level of the free-space gap search
// samples are held in s1_item_reg; a scan's result is registered in out_data_reg
// throughput: one sample per cycle; the input stalls only when a scan-end sample
//   meets a result still held by a stalled output register
// reset: asynchronous active low; clears handshake, scan state and config to defaults
// depends on lsgs_pkg, lsgs_cfg, lsgs_step
module laser_scan_gap_selector_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  lsgs_pkg::lsgs_in_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output lsgs_pkg::lsgs_out_t out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data
);
    import lsgs_pkg::*;

    lsgs_cfg_t   cfg;
    logic        s1_valid_reg;
    logic        s1_valid_next;
    lsgs_in_t    s1_item_reg;
    lsgs_state_t state_reg;
    lsgs_state_t step_state;
    logic        step_end;
    lsgs_out_t   step_result;
    logic        out_valid_reg;
    logic        out_valid_next;
    lsgs_out_t   out_data_reg;
    logic        fire;
    logic        in_xfer;

    lsgs_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lsgs_step u_step (
        .item       (s1_item_reg),
        .cfg        (cfg),
        .state      (state_reg),
        .state_next (step_state),
        .scan_end   (step_end),
        .result     (step_result)
    );

    // a sample moves on unless it ends a scan and the result slot is blocked
    assign fire     = s1_valid_reg && (!step_end || !out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !fire;
    assign in_xfer  = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_xfer)
            s1_valid_next = 1'b1;
        else if (fire)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (fire && step_end)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (fire)
                state_reg <= step_state;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
            s1_item_reg <= in_data;
        if (fire && step_end)
            out_data_reg <= step_result;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// File: rtl/lsgs_checker.sv
// lsgs_checker: port-level assertions for the gap selector top level
// depends on lsgs_pkg; bound to laser_scan_gap_selector_core below
module lsgs_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input lsgs_pkg::lsgs_out_t out_data,
    input logic               cfg_valid,
    input logic               cfg_ready
);
    import lsgs_pkg::*;

    // a held result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_data))
        else $error("result changed while stalled");

    // no gap means index zero
    a_no_gap_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.gap_found |-> out_data.gap_index == 8'd0)
        else $error("nonzero index without a gap");

    // input backs up only behind a blocked result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled with free output");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("config write refused");

endmodule

bind laser_scan_gap_selector_core lsgs_checker u_lsgs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);
